FILE: rtl/jsu_pkg.sv
// Shared types, status codes and the UTF-8 encoder for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

	localparam logic [1:0] ST_DATA  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;
	localparam logic [1:0] TERM_NONE = 2'd0;

	localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
	localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
	localparam logic [20:0] SUPP_BASE     = 21'h10000;
	localparam logic [20:0] LIM_ONE       = 21'h80;
	localparam logic [20:0] LIM_TWO       = 21'h800;
	localparam logic [20:0] LIM_THREE     = 21'h10000;

	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      nb;
		logic [1:0]      term;
	} jsu_rec_t;

	function automatic jsu_rec_t utf8_encode(input logic [20:0] cp);
		jsu_rec_t r;
		r = '0;
		if (cp < LIM_ONE) begin
			r.data[0] = cp[7:0];
			r.nb = 3'd1;
		end else if (cp < LIM_TWO) begin
			r.data[0] = {3'b110, cp[10:6]};
			r.data[1] = {2'b10, cp[5:0]};
			r.nb = 3'd2;
		end else if (cp < LIM_THREE) begin
			r.data[0] = {4'b1110, cp[15:12]};
			r.data[1] = {2'b10, cp[11:6]};
			r.data[2] = {2'b10, cp[5:0]};
			r.nb = 3'd3;
		end else begin
			r.data[0] = {5'b11110, cp[20:18]};
			r.data[1] = {2'b10, cp[17:12]};
			r.data[2] = {2'b10, cp[11:6]};
			r.data[3] = {2'b10, cp[5:0]};
			r.nb = 3'd4;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/jsu_front.sv
// Front end: per-byte escape parser that turns each input byte into at most one result record.
`timescale 1ns / 1ps
`default_nettype none
module jsu_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       in_byte,
	input  wire logic             in_eob,
	input  wire logic             full,
	output logic                  push,
	output jsu_pkg::jsu_rec_t     rec
);
	import jsu_pkg::*;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_BODY    = 3'd1;
	localparam logic [2:0] PH_ESC     = 3'd2;
	localparam logic [2:0] PH_HEX1    = 3'd3;
	localparam logic [2:0] PH_PAIR_BS = 3'd4;
	localparam logic [2:0] PH_PAIR_U  = 3'd5;
	localparam logic [2:0] PH_HEX2    = 3'd6;
	localparam logic [2:0] PH_DISCARD = 3'd7;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	logic [2:0]  phase_q, phase_n;
	logic [15:0] first_q, first_n;
	logic [15:0] second_q, second_n;
	logic [1:0]  cnt_q, cnt_n;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic        accept;
	jsu_rec_t    r;

	assign in_ready = !full;
	assign accept = in_valid && in_ready;

	always_comb begin
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) hex_val = in_byte[3:0];
		else if ((in_byte >= 8'h61 && in_byte <= 8'h66) || (in_byte >= 8'h41 && in_byte <= 8'h46))
			hex_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
		else hex_ok = 1'b0;
	end

	always_comb begin
		phase_n = phase_q;
		first_n = first_q;
		second_n = second_q;
		cnt_n = cnt_q;
		r = '0;
		unique case (phase_q)
			PH_BODY: begin
				if (in_byte == CH_QUOTE) r.term = ST_DONE;
				else if (in_byte == CH_BSL) phase_n = PH_ESC;
				else if (in_byte < CH_SPACE) r.term = ST_ERROR;
				else begin
					r.data[0] = in_byte;
					r.nb = 3'd1;
				end
			end
			PH_ESC: begin
				phase_n = PH_BODY;
				r.nb = 3'd1;
				case (in_byte)
					CH_QUOTE, CH_BSL, CH_SLASH: r.data[0] = in_byte;
					8'h62: r.data[0] = 8'h08;
					8'h66: r.data[0] = 8'h0C;
					8'h6E: r.data[0] = 8'h0A;
					8'h72: r.data[0] = 8'h0D;
					8'h74: r.data[0] = 8'h09;
					CH_U: begin
						r.nb = 3'd0;
						phase_n = PH_HEX1;
						first_n = '0;
						cnt_n = '0;
					end
					default: begin
						r.nb = 3'd0;
						r.term = ST_ERROR;
					end
				endcase
			end
			PH_HEX1: begin
				if (!hex_ok) r.term = ST_ERROR;
				else begin
					first_n = {first_q[11:0], hex_val};
					cnt_n = cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (first_n[15:10] == SURR_HIGH_TAG) phase_n = PH_PAIR_BS;
						else if (first_n[15:10] == SURR_LOW_TAG) r.term = ST_ERROR;
						else begin
							r = utf8_encode({5'd0, first_n});
							phase_n = PH_BODY;
						end
					end
				end
			end
			PH_PAIR_BS: begin
				if (in_byte == CH_BSL) phase_n = PH_PAIR_U;
				else r.term = ST_ERROR;
			end
			PH_PAIR_U: begin
				if (in_byte == CH_U) begin
					phase_n = PH_HEX2;
					second_n = '0;
					cnt_n = '0;
				end else r.term = ST_ERROR;
			end
			PH_HEX2: begin
				if (!hex_ok) r.term = ST_ERROR;
				else begin
					second_n = {second_q[11:0], hex_val};
					cnt_n = cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (second_n[15:10] == SURR_LOW_TAG) begin
							r = utf8_encode(SUPP_BASE + {1'b0, first_q[9:0], second_n[9:0]});
							phase_n = PH_BODY;
						end else r.term = ST_ERROR;
					end
				end
			end
			PH_DISCARD: begin
			end
			default: begin
				if (in_byte == CH_QUOTE) phase_n = PH_BODY;
				else r.term = ST_ERROR;
			end
		endcase

		if (r.term == TERM_NONE && in_eob && phase_q != PH_DISCARD) r.term = ST_ERROR;
		if (r.term == ST_ERROR) r.nb = 3'd0;
		if (r.term != TERM_NONE || in_eob) begin
			phase_n = (r.term == ST_ERROR && !in_eob) ? PH_DISCARD : PH_IDLE;
			first_n = '0;
			second_n = '0;
			cnt_n = '0;
		end
	end

	assign rec = r;
	assign push = accept && (r.nb != 3'd0 || r.term != TERM_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= '0;
			second_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			first_q <= first_n;
			second_q <= second_n;
			cnt_q <= cnt_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/jsu_fifo.sv
// Short record queue between the parser front end and the output back end.
`timescale 1ns / 1ps
`default_nettype none
module jsu_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire jsu_pkg::jsu_rec_t wr_rec,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output jsu_pkg::jsu_rec_t      rd_rec
);
	import jsu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_rec_t      mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_rec = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/jsu_back.sv
// Back end: holds one record and emits its data bytes and terminal status one transfer at a time.
`timescale 1ns / 1ps
`default_nettype none
module jsu_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire jsu_pkg::jsu_rec_t head_rec,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);
	import jsu_pkg::*;

	jsu_rec_t   cur_q;
	logic       cur_v_q;
	logic [2:0] idx_q;
	logic       is_data;
	logic [7:0] byte_out;
	logic [1:0] status;
	logic       fin;
	logic       load;

	assign is_data = idx_q < cur_q.nb;
	assign byte_out = is_data ? cur_q.data[idx_q[1:0]] : 8'd0;
	assign status = is_data ? ST_DATA : cur_q.term;
	assign fin = (cur_q.term == TERM_NONE) ? (idx_q + 3'd1 == cur_q.nb) : !is_data;

	assign m_tvalid = cur_v_q;
	assign m_tdata = byte_out;
	assign m_tuser = status;
	assign m_tlast = fin;

	assign load = !cur_v_q || (m_tready && fin);
	assign pop = load && head_valid;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			cur_v_q <= head_valid;
			idx_q <= '0;
		end else if (m_tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Takes one raw byte of a quoted JSON string per transfer and returns the decoded bytes,
// then a done or error result. Input bytes are taken one per cycle; the parser turns each
// into at most one record of up to four UTF-8 bytes plus an optional status, queued in a
// four-entry queue. The output side sends one result per cycle while m_tready is high;
// sustained input rate is one byte per cycle while the bytes average one result or fewer,
// and otherwise it is set by the output, one result per cycle. Input is stalled only when
// the queue is full. A result passes through the queue and the back end's record register.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // end_of_buffer
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic [1:0]       m_tuser,   // [1:0] status
	output logic             m_tlast    // last
);
	import jsu_pkg::*;

	logic     push, full, pop, head_valid;
	jsu_rec_t wr_rec, head_rec;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_eob   (s_tlast),
		.full     (full),
		.push     (push),
		.rec      (wr_rec)
	);

	jsu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (wr_rec),
		.full      (full),
		.pop       (pop),
		.not_empty (head_valid),
		.rd_rec    (head_rec)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

`ifndef SYNTHESIS
	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_DATA |-> m_tlast)
		else $error("status result not marked last");
	a_term_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_DATA |-> m_tdata == 8'd0)
		else $error("status result carries nonzero byte");
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ST_ERROR)
		else $error("illegal status");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/json_string_unescape_utf8_tb.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps
module json_string_unescape_utf8_tb;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 500;
	localparam int MAX_REPORTS = 10;
	localparam int RX_HOLD_CYCLES = 300;

	typedef enum logic [3:0] {
		PH_IDLE, PH_BODY, PH_ESC, PH_HEX1, PH_PAIR_BS, PH_PAIR_U, PH_HEX2, PH_DISCARD
	} scan_phase_t;

	typedef struct packed {
		logic [7:0] value;
		logic [1:0] status;
		logic       last;
	} dec_result_t;

	typedef struct {
		logic [7:0]  value;
		logic        eob;
		bit          typed;
		bit          has_res;
		dec_result_t res;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] in_byte
	logic        s_tlast;   // end_of_buffer
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] out_byte
	logic [1:0]  m_tuser;   // [1:0] status
	logic        m_tlast;   // last

	scan_phase_t scan_phase;
	logic [15:0] lead_unit;
	logic [15:0] trail_unit;
	logic [1:0]  hex_digits;

	dec_result_t decoded_q[$];
	byte_item_t  directed_rows[$];
	int          fail_count = 0;
	int          results_seen = 0;
	int          random_items = 0;
	bit          hold_rx = 1'b0;
	bit          quiet = 1'b0;

	json_string_unescape_utf8 u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return {1'b0, c[3:0]};
		end
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
			return {1'b0, c[3:0] + 4'd9};
		end
		return 5'h10;
	endfunction

	task automatic utf8_seq(input logic [20:0] cp, output logic [7:0] seq [4], output int len);
		seq[0] = 8'h00;
		seq[1] = 8'h00;
		seq[2] = 8'h00;
		seq[3] = 8'h00;
		if (cp < 21'h80) begin
			seq[0] = cp[7:0];
			len = 1;
		end else if (cp < 21'h800) begin
			seq[0] = 8'hC0 | {3'b000, cp[10:6]};
			seq[1] = 8'h80 | {2'b00, cp[5:0]};
			len = 2;
		end else if (cp < 21'h10000) begin
			seq[0] = 8'hE0 | {4'b0000, cp[15:12]};
			seq[1] = 8'h80 | {2'b00, cp[11:6]};
			seq[2] = 8'h80 | {2'b00, cp[5:0]};
			len = 3;
		end else begin
			seq[0] = 8'hF0 | {5'b00000, cp[20:18]};
			seq[1] = 8'h80 | {2'b00, cp[17:12]};
			seq[2] = 8'h80 | {2'b00, cp[11:6]};
			seq[3] = 8'h80 | {2'b00, cp[5:0]};
			len = 4;
		end
	endtask

	task automatic unescape_step(input logic [7:0] b, input logic eob,
			output dec_result_t res [4], output int n);
		logic [7:0]  seq [4];
		int          nb;
		int          i;
		logic [1:0]  term;
		scan_phase_t start;
		scan_phase_t nxt;
		logic [4:0]  nib;
		start = scan_phase;
		nxt = scan_phase;
		term = TERM_NONE;
		nb = 0;
		n = 0;
		nib = hex_nibble(b);
		for (i = 0; i < 4; i++) begin
			seq[i] = 8'h00;
			res[i] = '0;
		end
		case (start)
			PH_BODY: begin
				if (b == "\"") begin
					term = ST_DONE;
				end else if (b == "\\") begin
					nxt = PH_ESC;
				end else if (b < 8'h20) begin
					term = ST_ERROR;
				end else begin
					seq[0] = b;
					nb = 1;
				end
			end
			PH_ESC: begin
				nxt = PH_BODY;
				nb = 1;
				case (b)
					"\"", "\\", "/": seq[0] = b;
					"b": seq[0] = 8'h08;
					"f": seq[0] = 8'h0C;
					"n": seq[0] = 8'h0A;
					"r": seq[0] = 8'h0D;
					"t": seq[0] = 8'h09;
					"u": begin
						nb = 0;
						nxt = PH_HEX1;
						lead_unit = '0;
						hex_digits = '0;
					end
					default: begin
						nb = 0;
						term = ST_ERROR;
					end
				endcase
			end
			PH_HEX1: begin
				if (nib[4]) begin
					term = ST_ERROR;
				end else begin
					lead_unit = {lead_unit[11:0], nib[3:0]};
					if (hex_digits != 2'd3) begin
						hex_digits++;
					end else begin
						hex_digits = '0;
						if (lead_unit[15:10] == SURR_HIGH_TAG) begin
							nxt = PH_PAIR_BS;
						end else if (lead_unit[15:10] == SURR_LOW_TAG) begin
							term = ST_ERROR;
						end else begin
							utf8_seq({5'd0, lead_unit}, seq, nb);
							nxt = PH_BODY;
						end
					end
				end
			end
			PH_PAIR_BS: begin
				if (b == "\\") begin
					nxt = PH_PAIR_U;
				end else begin
					term = ST_ERROR;
				end
			end
			PH_PAIR_U: begin
				if (b == "u") begin
					nxt = PH_HEX2;
					trail_unit = '0;
					hex_digits = '0;
				end else begin
					term = ST_ERROR;
				end
			end
			PH_HEX2: begin
				if (nib[4]) begin
					term = ST_ERROR;
				end else begin
					trail_unit = {trail_unit[11:0], nib[3:0]};
					if (hex_digits != 2'd3) begin
						hex_digits++;
					end else begin
						hex_digits = '0;
						if (trail_unit[15:10] == SURR_LOW_TAG) begin
							utf8_seq(21'h10000 + {1'b0, lead_unit[9:0], trail_unit[9:0]}, seq, nb);
							nxt = PH_BODY;
						end else begin
							term = ST_ERROR;
						end
					end
				end
			end
			PH_DISCARD: begin
			end
			default: begin
				if (b == "\"") begin
					nxt = PH_BODY;
				end else begin
					term = ST_ERROR;
				end
			end
		endcase
		if (term == TERM_NONE && eob && start != PH_DISCARD) begin
			term = ST_ERROR;
		end
		if (term == ST_ERROR) begin
			nb = 0;
		end
		if (term != TERM_NONE || eob) begin
			nxt = (term == ST_ERROR && !eob) ? PH_DISCARD : PH_IDLE;
			lead_unit = '0;
			trail_unit = '0;
			hex_digits = '0;
		end
		scan_phase = nxt;
		for (i = 0; i < nb; i++) begin
			res[n] = '{value: seq[i], status: ST_DATA, last: 1'b0};
			n++;
		end
		if (term != TERM_NONE) begin
			res[n] = '{value: 8'h00, status: term, last: 1'b0};
			n++;
		end
		if (n > 0) begin
			res[n - 1].last = 1'b1;
		end
	endtask

	task automatic flag_error(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("ERROR at %0t: %s", $realtime, what);
		end
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input byte_item_t it);
		dec_result_t got [4];
		int          n;
		int          i;
		int          gap;
		s_tdata <= it.value;
		s_tlast <= it.eob;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		unescape_step(it.value, it.eob, got, n);
		if (it.typed) begin
			if (it.has_res) begin
				decoded_q.push_back(it.res);
			end
		end else begin
			for (i = 0; i < n; i++) begin
				decoded_q.push_back(got[i]);
			end
		end
		gap = (quiet || hold_rx) ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (decoded_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic add_row(input logic [7:0] value, input logic eob);
		byte_item_t it;
		it.value = value;
		it.eob = eob;
		it.typed = 1'b0;
		it.has_res = 1'b0;
		it.res = '0;
		directed_rows.push_back(it);
	endtask

	task automatic add_typed(input logic [7:0] value, input logic eob, input bit has_res,
			input logic [1:0] status, input logic [7:0] out_value);
		byte_item_t it;
		it.value = value;
		it.eob = eob;
		it.typed = 1'b1;
		it.has_res = has_res;
		it.res = '{value: out_value, status: status, last: 1'b1};
		directed_rows.push_back(it);
	endtask

	task automatic emit(input logic [7:0] value, input logic eob, input bit counted);
		byte_item_t it;
		it.value = value;
		it.eob = eob;
		it.typed = 1'b0;
		it.has_res = 1'b0;
		it.res = '0;
		send_byte(it);
		if (counted) begin
			random_items++;
		end
	endtask

	task automatic emit_digit(input logic [3:0] nib, input logic eob);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + nib;
		end else begin
			c = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10;
		end
		emit(c, eob, 1'b1);
	endtask

	task automatic emit_unit(input logic [15:0] u, input logic eob);
		emit("\\", 1'b0, 1'b1);
		emit("u", 1'b0, 1'b1);
		emit_digit(u[15:12], 1'b0);
		emit_digit(u[11:8], 1'b0);
		emit_digit(u[7:4], 1'b0);
		emit_digit(u[3:0], eob);
	endtask

	function automatic logic [15:0] rand_surrogate(input logic [5:0] tag);
		logic [9:0] low_bits;
		low_bits = 10'($urandom);
		return {tag, low_bits};
	endfunction

	function automatic bit is_escape(input logic [7:0] c);
		case (c)
			"\"", "\\", "/", "b", "f", "n", "r", "t", "u": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] pick_escape();
		case ($urandom_range(0, 7))
			0: return "\"";
			1: return "\\";
			2: return "/";
			3: return "b";
			4: return "f";
			5: return "n";
			6: return "r";
			default: return "t";
		endcase
	endfunction

	task automatic emit_token();
		logic [7:0]  b;
		logic [15:0] u;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				b = 8'($urandom_range(8'h20, 8'hFF));
				if (b == "\"" || b == "\\") begin
					b = b ^ 8'h01;
				end
				emit(b, 1'b0, 1'b1);
			end
			5, 6: begin
				emit("\\", 1'b0, 1'b1);
				emit(pick_escape(), 1'b0, 1'b1);
			end
			7, 8: begin
				case ($urandom_range(0, 2))
					0: u = 16'($urandom_range(16'h0000, 16'h007F));
					1: u = 16'($urandom_range(16'h0080, 16'h07FF));
					default: u = 16'($urandom_range(16'h0800, 16'hFFFF));
				endcase
				if (u[15:11] == 5'b11011) begin
					u[14] = ~u[14];
				end
				emit_unit(u, 1'b0);
			end
			default: begin
				emit_unit(rand_surrogate(SURR_HIGH_TAG), 1'b0);
				emit_unit(rand_surrogate(SURR_LOW_TAG), 1'b0);
			end
		endcase
	endtask

	task automatic emit_string();
		emit("\"", 1'b0, 1'b1);
		repeat ($urandom_range(0, 10)) emit_token();
		emit("\"", 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic emit_broken();
		logic [7:0]  b;
		logic [15:0] u;
		logic [4:0]  nib;
		int          fault;
		logic        fault_eob;
		fault = $urandom_range(0, 8);
		fault_eob = ($urandom_range(0, 3) == 0);
		if (fault != 8) begin
			emit("\"", 1'b0, 1'b1);
			repeat ($urandom_range(0, 4)) emit_token();
		end
		case (fault)
			0: emit(8'($urandom_range(8'h00, 8'h1F)), fault_eob, 1'b1);
			1: begin
				emit("\\", 1'b0, 1'b1);
				do b = 8'($urandom); while (is_escape(b));
				emit(b, fault_eob, 1'b1);
			end
			2: begin
				if ($urandom_range(0, 1)) begin
					emit_unit(rand_surrogate(SURR_HIGH_TAG), 1'b0);
				end
				emit("\\", 1'b0, 1'b1);
				emit("u", 1'b0, 1'b1);
				repeat ($urandom_range(0, 3)) emit_digit(4'($urandom_range(0, 15)), 1'b0);
				do begin
					b = 8'($urandom);
					nib = hex_nibble(b);
				end while (!nib[4]);
				emit(b, fault_eob, 1'b1);
			end
			3: emit_unit(rand_surrogate(SURR_LOW_TAG), fault_eob);
			4: begin
				emit_unit(rand_surrogate(SURR_HIGH_TAG), 1'b0);
				do b = 8'($urandom); while (b == "\\");
				emit(b, fault_eob, 1'b1);
			end
			5: begin
				emit_unit(rand_surrogate(SURR_HIGH_TAG), 1'b0);
				emit("\\", 1'b0, 1'b1);
				do b = 8'($urandom); while (b == "u");
				emit(b, fault_eob, 1'b1);
			end
			6: begin
				emit_unit(rand_surrogate(SURR_HIGH_TAG), 1'b0);
				u = 16'($urandom);
				if (u[15:10] == SURR_LOW_TAG) begin
					u[15] = ~u[15];
				end
				emit_unit(u, fault_eob);
			end
			7: begin
				fault_eob = 1'b1;
				case ($urandom_range(0, 2))
					0: begin
						do b = 8'($urandom); while (b == "\"");
						emit(b, 1'b1, 1'b1);
					end
					1: emit("\\", 1'b1, 1'b1);
					default: begin
						emit("\\", 1'b0, 1'b1);
						emit("u", 1'b0, 1'b1);
						repeat ($urandom_range(0, 3)) emit_digit(4'($urandom_range(0, 15)), 1'b0);
						emit_digit(4'($urandom_range(0, 15)), 1'b1);
					end
				endcase
			end
			default: begin
				do b = 8'($urandom); while (b == "\"");
				emit(b, fault_eob, 1'b1);
			end
		endcase
		if (!fault_eob) begin
			repeat ($urandom_range(0, 3)) emit(8'($urandom), 1'b0, 1'b0);
			emit(8'($urandom), 1'b1, 1'b0);
		end
	endtask

	task automatic emit_noise();
		repeat ($urandom_range(1, 6)) emit(8'($urandom), ($urandom_range(0, 3) == 0), 1'b1);
		emit(8'($urandom), 1'b1, 1'b1);
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : rx_side
		int n;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				m_tready <= 1'b1;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
				repeat (n) @(posedge clk);
				n = idle_len();
				if (n > 0) begin
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		dec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (decoded_q.size() == 0) begin
				flag_error($sformatf("result %0d unexpected: tdata=%h tuser=%0d tlast=%b",
					results_seen, m_tdata, m_tuser, m_tlast));
			end else begin
				want = decoded_q.pop_front();
				if (m_tdata !== want.value || m_tuser !== want.status ||
						m_tlast !== want.last) begin
					flag_error($sformatf("result %0d: want %h/%0d/%b got %h/%0d/%b",
						results_seen, want.value, want.status, want.last,
						m_tdata, m_tuser, m_tlast));
				end
			end
		end
	end

	initial begin
		bit stall_done;
		bit pause_done;
		int r;
		stall_done = 1'b0;
		pause_done = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		scan_phase = PH_IDLE;
		lead_unit = '0;
		trail_unit = '0;
		hex_digits = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_typed(8'h00, 1'b0, 1'b1, ST_ERROR, 8'h00);
		add_typed(8'hFF, 1'b1, 1'b0, ST_DATA, 8'h00);
		add_typed("\"", 1'b1, 1'b1, ST_ERROR, 8'h00);
		add_typed("\"", 1'b0, 1'b0, ST_DATA, 8'h00);
		add_typed(8'hFF, 1'b0, 1'b1, ST_DATA, 8'hFF);
		add_typed("\\", 1'b0, 1'b0, ST_DATA, 8'h00);
		add_row("/", 1'b0);
		add_typed("\\", 1'b0, 1'b0, ST_DATA, 8'h00);
		add_typed("u", 1'b0, 1'b0, ST_DATA, 8'h00);
		add_typed("0", 1'b0, 1'b0, ST_DATA, 8'h00);
		add_typed("0", 1'b0, 1'b0, ST_DATA, 8'h00);
		add_typed("0", 1'b0, 1'b0, ST_DATA, 8'h00);
		add_typed("0", 1'b0, 1'b1, ST_DATA, 8'h00);
		add_row("\\", 1'b0);
		add_row("u", 1'b0);
		add_row("D", 1'b0);
		add_row("b", 1'b0);
		add_row("F", 1'b0);
		add_row("f", 1'b0);
		add_row("\\", 1'b0);
		add_row("u", 1'b0);
		add_row("d", 1'b0);
		add_row("F", 1'b0);
		add_row("f", 1'b0);
		add_row("F", 1'b0);
		add_typed("\"", 1'b0, 1'b1, ST_DONE, 8'h00);
		add_typed("\"", 1'b0, 1'b0, ST_DATA, 8'h00);
		add_typed(8'h1F, 1'b1, 1'b1, ST_ERROR, 8'h00);
		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i]);
		end
		wait_drained();

		while (random_items < RANDOM_ITEMS) begin
			if (!stall_done && random_items >= 150) begin
				hold_rx = 1'b1;
				stall_done = 1'b1;
			end
			if (!pause_done && random_items >= 350) begin
				wait_drained();
				pause_done = 1'b1;
			end
			quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 60) begin
				emit_string();
			end else if (r < 90) begin
				emit_broken();
			end else begin
				emit_noise();
			end
		end
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
